>>> hw/rtl/atcw_pkg.sv
// shared types, constants and helper functions for the ansi text console writer
// depends on nothing; used by every module of the block by scoped names
package atcw_pkg;

    // screen geometry
    localparam int SCREEN_COLS = 80;
    localparam int SCREEN_ROWS = 25;

    localparam int ROW_W = 5;
    localparam int COL_W = 7;
    localparam int POS_W = 11;
    localparam int ACC_W = 8;

    localparam logic [ROW_W-1:0] LAST_ROW   = ROW_W'(SCREEN_ROWS - 1);
    localparam logic [COL_W-1:0] LAST_COL   = COL_W'(SCREEN_COLS - 1);
    localparam logic [POS_W-1:0] LAST_ROW_POS = POS_W'((SCREEN_ROWS - 1) * SCREEN_COLS);
    localparam logic [POS_W-1:0] COLS_POS   = POS_W'(SCREEN_COLS);

    // character codes
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_LBR   = 8'h5B;
    localparam logic [7:0] CH_M     = 8'h6D;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // sgr codes
    localparam logic [ACC_W-1:0] SGR_RESET  = 8'd0;
    localparam logic [ACC_W-1:0] SGR_FG_LO  = 8'd30;
    localparam logic [ACC_W-1:0] SGR_FG_HI  = 8'd37;
    localparam logic [ACC_W-1:0] SGR_BG_LO  = 8'd40;
    localparam logic [ACC_W-1:0] SGR_BG_HI  = 8'd47;
    localparam logic [ACC_W-1:0] ACC_MAX    = 8'd255;

    localparam logic [7:0] ATTR_DEFAULT = 8'h07;

    localparam int TDATA_W = 64;

    typedef enum logic [1:0] {
        PH_TEXT = 2'd0,
        PH_ESC  = 2'd1,
        PH_CSI  = 2'd2
    } phase_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [POS_W-1:0] pos;
    } cursor_t;

    // first member sits in the highest bits, so cell_write ends up at bit 0
    typedef struct packed {
        logic [POS_W-1:0] cursor_pos;
        logic             cursor_write;
        logic [15:0]      blank_entry;
        logic             scroll_up;
        logic [15:0]      cell_entry;
        logic [POS_W-1:0] cell_index;
        logic             cell_write;
    } res_t;

    typedef struct packed {
        logic last;
        res_t res;
    } entry_t;

    typedef struct packed {
        res_t    res;
        cursor_t cur;
    } plain_t;

    // ansi color number to vga color number
    function automatic logic [3:0] ansi_to_vga(input logic [2:0] c);
        logic [3:0] v;
        case (c)
            3'd0:    v = 4'd0;
            3'd1:    v = 4'd4;
            3'd2:    v = 4'd2;
            3'd3:    v = 4'd6;
            3'd4:    v = 4'd1;
            3'd5:    v = 4'd5;
            3'd6:    v = 4'd3;
            default: v = 4'd15;
        endcase
        return v;
    endfunction

    // one plain-text byte: newline or printed cell, with cursor advance
    function automatic plain_t emit_plain(input cursor_t cur, input logic [7:0] b,
                                          input logic [7:0] attr);
        plain_t p;
        logic   wrap_row;
        logic   bottom;
        p.cur = cur;
        p.res = '0;
        p.res.blank_entry = {attr, CH_SP};
        bottom = (cur.row == LAST_ROW);
        if (b == CH_NL)
        begin
            p.cur.col = '0;
            if (bottom)
            begin
                p.cur.pos = LAST_ROW_POS;
                p.res.scroll_up = 1'b1;
            end
            else
            begin
                p.cur.row = cur.row + 1'b1;
                p.cur.pos = cur.pos - POS_W'(cur.col) + COLS_POS;
            end
        end
        else
        begin
            wrap_row = (cur.col == LAST_COL);
            p.res.cell_write   = 1'b1;
            p.res.cell_index   = cur.pos;
            p.res.cell_entry   = {attr, b};
            p.res.cursor_write = 1'b1;
            if (!wrap_row)
            begin
                p.cur.col = cur.col + 1'b1;
                p.cur.pos = cur.pos + 1'b1;
            end
            else
            begin
                p.cur.col = '0;
                if (bottom)
                begin
                    p.cur.pos = LAST_ROW_POS;
                    p.res.scroll_up = 1'b1;
                end
                else
                begin
                    p.cur.row = cur.row + 1'b1;
                    p.cur.pos = cur.pos + 1'b1;
                end
            end
            p.res.cursor_pos = p.cur.pos;
        end
        return p;
    endfunction

endpackage

>>> hw/rtl/atcw_decoder.sv
// escape parser, attribute and cursor state; turns one byte into up to two results
// depends on atcw_pkg
module atcw_decoder
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  take,
    input  logic [7:0]            ch,
    output logic [1:0]            push_cnt,
    output atcw_pkg::entry_t      push0,
    output atcw_pkg::entry_t      push1
);

    atcw_pkg::phase_t  phase_reg, phase_next;
    logic [atcw_pkg::ACC_W-1:0] accum_reg, accum_next;
    logic [7:0]        attr_reg, attr_next;
    atcw_pkg::cursor_t cur_reg, cur_next;

    atcw_pkg::plain_t  p_esc;
    atcw_pkg::plain_t  p_byte_a;
    atcw_pkg::plain_t  p_byte_b;
    logic              is_digit;
    logic [11:0]       acc_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= atcw_pkg::PH_TEXT;
            accum_reg <= '0;
            attr_reg  <= atcw_pkg::ATTR_DEFAULT;
            cur_reg   <= '0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            accum_reg <= accum_next;
            attr_reg  <= attr_next;
            cur_reg   <= cur_next;
        end
    end

    always_comb
    begin
        is_digit = (ch >= atcw_pkg::CH_ZERO) && (ch <= atcw_pkg::CH_NINE);
        acc_sum  = 12'(accum_reg) * 12'd10 + 12'(ch - atcw_pkg::CH_ZERO);
        // pending esc printed first, then the byte from the advanced cursor
        p_esc    = atcw_pkg::emit_plain(cur_reg, atcw_pkg::CH_ESC, attr_reg);
        p_byte_a = atcw_pkg::emit_plain(cur_reg, ch, attr_reg);
        p_byte_b = atcw_pkg::emit_plain(p_esc.cur, ch, attr_reg);

        phase_next = phase_reg;
        accum_next = accum_reg;
        attr_next  = attr_reg;
        cur_next   = cur_reg;
        push_cnt   = 2'd0;
        push0      = '0;
        push1      = '0;

        unique case (phase_reg)
            atcw_pkg::PH_CSI:
            begin
                if (is_digit)
                begin
                    accum_next = (acc_sum > 12'(atcw_pkg::ACC_MAX)) ? atcw_pkg::ACC_MAX
                                                                    : acc_sum[7:0];
                end
                else
                begin
                    phase_next = atcw_pkg::PH_TEXT;
                    if (ch == atcw_pkg::CH_M)
                    begin
                        if (accum_reg == atcw_pkg::SGR_RESET)
                            attr_next = atcw_pkg::ATTR_DEFAULT;
                        else if (accum_reg >= atcw_pkg::SGR_FG_LO &&
                                 accum_reg <= atcw_pkg::SGR_FG_HI)
                            attr_next = {attr_reg[7:4], atcw_pkg::ansi_to_vga(accum_reg[2:0]
                                         - 3'd6)};
                        else if (accum_reg >= atcw_pkg::SGR_BG_LO &&
                                 accum_reg <= atcw_pkg::SGR_BG_HI)
                            attr_next = {atcw_pkg::ansi_to_vga(accum_reg[2:0]),
                                         attr_reg[3:0]};
                    end
                end
            end
            atcw_pkg::PH_ESC:
            begin
                if (ch == atcw_pkg::CH_LBR)
                begin
                    phase_next = atcw_pkg::PH_CSI;
                    accum_next = '0;
                end
                else
                begin
                    push0.res = p_esc.res;
                    if (ch == atcw_pkg::CH_ESC)
                    begin
                        phase_next = atcw_pkg::PH_ESC;
                        cur_next   = p_esc.cur;
                        push_cnt   = 2'd1;
                        push0.last = 1'b1;
                    end
                    else
                    begin
                        phase_next = atcw_pkg::PH_TEXT;
                        cur_next   = p_byte_b.cur;
                        push_cnt   = 2'd2;
                        push1.res  = p_byte_b.res;
                        push1.last = 1'b1;
                    end
                end
            end
            default:
            begin
                // plain text, and the unused phase code
                if (ch == atcw_pkg::CH_ESC)
                begin
                    phase_next = atcw_pkg::PH_ESC;
                end
                else
                begin
                    phase_next = atcw_pkg::PH_TEXT;
                    cur_next   = p_byte_a.cur;
                    push_cnt   = 2'd1;
                    push0.res  = p_byte_a.res;
                    push0.last = 1'b1;
                end
            end
        endcase

        // results reach the queue only for a byte that is consumed this cycle
        if (!take)
            push_cnt = 2'd0;
    end

endmodule

>>> hw/rtl/atcw_result_fifo.sv
// four-entry result queue, up to two pushes and one pop per cycle
// depends on atcw_pkg
module atcw_result_fifo
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [1:0]       push_cnt,
    input  atcw_pkg::entry_t push0,
    input  atcw_pkg::entry_t push1,
    input  logic             pop,
    output atcw_pkg::entry_t head,
    output logic             head_valid,
    output logic             space2
);

    atcw_pkg::entry_t mem_reg [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;
    logic [1:0] wr_ptr_inc;
    logic       do_pop;

    always_comb
    begin
        do_pop      = pop && (count_reg != 3'd0);
        wr_ptr_inc  = wr_ptr_reg + 2'd1;
        wr_ptr_next = wr_ptr_reg + push_cnt;
        rd_ptr_next = rd_ptr_reg + 2'(do_pop);
        count_next  = count_reg + 3'(push_cnt) - 3'(do_pop);
        head        = mem_reg[rd_ptr_reg];
        head_valid  = (count_reg != 3'd0);
        space2      = (count_reg <= 3'd2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
            mem_reg[wr_ptr_reg] <= push0;
        if (push_cnt == 2'd2)
            mem_reg[wr_ptr_inc] <= push1;
    end

endmodule

>>> hw/rtl/ansi_text_console_writer_core.sv
// top level of the ansi text console writer: input register, decoder, result queue
// depends on atcw_pkg, atcw_decoder and atcw_result_fifo
//
// usage
//   s_axis carries one console byte per transaction (tdata[7:0] = ch)
//   m_axis carries text cell / cursor / scroll commands for the display memory;
//   tlast marks the final result caused by one input byte
//   a printed byte gives one result, a newline one, an esc that is not followed
//   by '[' gives an extra result ahead of the next byte; escape bytes give none
// data path
//   an accepted byte waits in the input register, is decoded from there into the
//   result queue, and leaves on m_axis from the head of that queue
// throughput
//   one byte per cycle while m_axis_tready is high and each byte gives at most
//   one result; a byte's two results leave in turn on the single result port
// reset
//   rst_n clears the parser to plain text, the attribute to light grey on black
//   (0x07), the cursor to row 0 column 0, and empties the input and result stages
// stalls
//   results wait in a four-entry queue; the input register keeps taking bytes
//   while two queue entries are free, so a stalled receiver backs up into
//   s_axis_tready only once fewer than two queue entries are free
module ansi_text_console_writer_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] ch
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] cell_write, [11:1] cell_index, [27:12] cell_entry, [28] scroll_up,
    // [44:29] blank_entry, [45] cursor_write, [56:46] cursor_pos, [63:57] zero
    output logic [atcw_pkg::TDATA_W-1:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    // input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_ch_reg;

    logic             take;
    logic             space2;
    logic [1:0]       push_cnt;
    atcw_pkg::entry_t push0;
    atcw_pkg::entry_t push1;
    atcw_pkg::entry_t head;
    logic             head_valid;

    // the decoder only runs when the queue can hold both possible results
    assign take          = in_valid_reg && space2;
    assign s_axis_tready = !in_valid_reg || space2;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_axis_tvalid && s_axis_tready)
            in_valid_next = 1'b1;
        else if (take)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            in_ch_reg <= s_axis_tdata;
    end

    atcw_decoder u_decoder
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (take),
        .ch       (in_ch_reg),
        .push_cnt (push_cnt),
        .push0    (push0),
        .push1    (push1)
    );

    atcw_result_fifo u_result_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cnt   (push_cnt),
        .push0      (push0),
        .push1      (push1),
        .pop        (m_axis_tready),
        .head       (head),
        .head_valid (head_valid),
        .space2     (space2)
    );

    // result fields packed from bit 0 up, padded to whole bytes
    assign m_axis_tvalid = head_valid;
    assign m_axis_tdata  = {{(atcw_pkg::TDATA_W - $bits(atcw_pkg::res_t)){1'b0}}, head.res};
    assign m_axis_tlast  = head.last;

endmodule

>>> dv/ansi_text_console_writer_core_tb.sv
// self-checking testbench for ansi_text_console_writer_core: byte stream in, cell commands out
// depends on atcw_pkg and the block rtl; expected commands: a local console model or typed-in rows
module ansi_text_console_writer_core_tb;

    localparam int QUIET_LIMIT  = 4000;   // cycles without any transaction before giving up
    localparam int DRAIN_CYCLES = 10;     // settle time after the last expected command
    localparam int RAND_ITEMS   = 600;
    localparam int RES_W        = $bits(atcw_pkg::res_t);

    // ansi color number to vga color number, entry 0 in the low nibble
    localparam logic [7:0][3:0] VGA_OF_ANSI =
        {4'd15, 4'd3, 4'd5, 4'd1, 4'd6, 4'd2, 4'd4, 4'd0};

    // first commands after reset, readable straight off the default attribute
    localparam atcw_pkg::res_t WANT_A   = '{cursor_pos: 11'd1, cursor_write: 1'b1,
                                  blank_entry: 16'h0720,
                                  scroll_up: 1'b0, cell_entry: 16'h0741, cell_index: 11'd0,
                                  cell_write: 1'b1};
    localparam atcw_pkg::res_t WANT_NUL = '{cursor_pos: 11'd2, cursor_write: 1'b1,
                                  blank_entry: 16'h0720,
                                  scroll_up: 1'b0, cell_entry: 16'h0700, cell_index: 11'd1,
                                  cell_write: 1'b1};
    localparam atcw_pkg::res_t WANT_FF  = '{cursor_pos: 11'd3, cursor_write: 1'b1,
                                  blank_entry: 16'h0720,
                                  scroll_up: 1'b0, cell_entry: 16'h07FF, cell_index: 11'd2,
                                  cell_write: 1'b1};
    localparam atcw_pkg::res_t WANT_NL  = '{cursor_pos: 11'd0, cursor_write: 1'b0,
                                  blank_entry: 16'h0720,
                                  scroll_up: 1'b0, cell_entry: 16'h0000, cell_index: 11'd0,
                                  cell_write: 1'b0};

    typedef struct packed {
        logic           last;
        atcw_pkg::res_t res;
    } cell_cmd_t;

    typedef struct packed {
        logic [7:0]     ch;
        logic           lit;    // 1 when want holds the typed-in command
        atcw_pkg::res_t want;
    } stim_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata;     // [7:0] ch
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    // [0] cell_write, [11:1] cell_index, [27:12] cell_entry, [28] scroll_up,
    // [44:29] blank_entry, [45] cursor_write, [56:46] cursor_pos, [63:57] zero
    logic [atcw_pkg::TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tlast;

    // console model state
    atcw_pkg::phase_t     esc_state = atcw_pkg::PH_TEXT;
    logic [7:0]           sgr_code  = '0;
    logic [7:0]           text_attr = atcw_pkg::ATTR_DEFAULT;
    logic [atcw_pkg::ROW_W-1:0] cur_row = '0;
    logic [atcw_pkg::COL_W-1:0] cur_col = '0;
    atcw_pkg::res_t       step_res [2];

    cell_cmd_t            cell_cmd_q [$];
    int                   fails = 0;
    int                   bytes_sent = 0;
    int                   quiet_cycles = 0;
    int                   src_idle_pct = 0;
    int                   dst_stall_pct = 0;
    stim_row_t            dir_tab [27];
    cell_cmd_t            mon_want;
    atcw_pkg::res_t       mon_got;

    ansi_text_console_writer_core u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // one plain-text byte: newline moves down, anything else writes a cell and advances
    function automatic atcw_pkg::res_t print_cell(input logic [7:0] b);
        atcw_pkg::res_t r;
        int             pos;
        r = '0;
        r.blank_entry = {text_attr, atcw_pkg::CH_SP};
        if (b == atcw_pkg::CH_NL)
        begin
            cur_col = '0;
            if (int'(cur_row) == atcw_pkg::SCREEN_ROWS - 1)
                r.scroll_up = 1'b1;
            else
                cur_row = cur_row + 1'b1;
        end
        else
        begin
            pos = int'(cur_row) * atcw_pkg::SCREEN_COLS + int'(cur_col);
            r.cell_write = 1'b1;
            r.cell_index = pos[atcw_pkg::POS_W-1:0];
            r.cell_entry = {text_attr, b};
            cur_col = cur_col + 1'b1;
            if (int'(cur_col) >= atcw_pkg::SCREEN_COLS)
            begin
                cur_col = '0;
                if (int'(cur_row) == atcw_pkg::SCREEN_ROWS - 1)
                    r.scroll_up = 1'b1;
                else
                    cur_row = cur_row + 1'b1;
            end
            pos = int'(cur_row) * atcw_pkg::SCREEN_COLS + int'(cur_col);
            r.cursor_write = 1'b1;
            r.cursor_pos   = pos[atcw_pkg::POS_W-1:0];
        end
        return r;
    endfunction

    // advance the console model by one byte; commands land in step_res, count returned
    function automatic int console_step(input logic [7:0] b);
        int n;
        int v;
        n = 0;
        if (esc_state == atcw_pkg::PH_CSI)
        begin
            if (b >= atcw_pkg::CH_ZERO && b <= atcw_pkg::CH_NINE)
            begin
                v = int'(sgr_code) * 10 + int'(b - atcw_pkg::CH_ZERO);
                sgr_code = (v > 255) ? atcw_pkg::ACC_MAX : v[7:0];
                return 0;
            end
            // any terminator ends the sequence, only 'm' applies the code
            if (b == atcw_pkg::CH_M)
            begin
                if (sgr_code == atcw_pkg::SGR_RESET)
                    text_attr = atcw_pkg::ATTR_DEFAULT;
                else if (sgr_code >= atcw_pkg::SGR_FG_LO && sgr_code <= atcw_pkg::SGR_FG_HI)
                    text_attr = {text_attr[7:4], VGA_OF_ANSI[sgr_code - atcw_pkg::SGR_FG_LO]};
                else if (sgr_code >= atcw_pkg::SGR_BG_LO && sgr_code <= atcw_pkg::SGR_BG_HI)
                    text_attr = {VGA_OF_ANSI[sgr_code - atcw_pkg::SGR_BG_LO], text_attr[3:0]};
            end
            esc_state = atcw_pkg::PH_TEXT;
            return 0;
        end
        if (esc_state == atcw_pkg::PH_ESC)
        begin
            if (b == atcw_pkg::CH_LBR)
            begin
                esc_state = atcw_pkg::PH_CSI;
                sgr_code  = '0;
                return 0;
            end
            // lone esc is printed ahead of this byte
            esc_state = atcw_pkg::PH_TEXT;
            step_res[n] = print_cell(atcw_pkg::CH_ESC);
            n++;
        end
        if (b == atcw_pkg::CH_ESC)
            esc_state = atcw_pkg::PH_ESC;
        else
        begin
            esc_state = atcw_pkg::PH_TEXT;
            step_res[n] = print_cell(b);
            n++;
        end
        return n;
    endfunction

    // drive one byte at the falling edge, wait for its transaction, log what it causes
    task automatic push_byte(input logic [7:0] b, input logic lit = 1'b0,
                             input atcw_pkg::res_t want = '0);
        int        n;
        cell_cmd_t cmd;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        n = console_step(b);
        for (int k = 0; k < n; k++)
        begin
            cmd.res  = lit ? want : step_res[k];
            cmd.last = (k == n - 1);
            cell_cmd_q.push_back(cmd);
        end
        bytes_sent++;
        @(negedge clk);
    endtask

    // decimal digits of an sgr code, optionally with leading zeros
    task automatic send_code(input int code, input int lead_zeros);
        int dig [4];
        int nd;
        int v;
        repeat (lead_zeros) push_byte(atcw_pkg::CH_ZERO);
        v  = code;
        nd = 0;
        do
        begin
            dig[nd] = v % 10;
            v = v / 10;
            nd++;
        end
        while (v > 0 && nd < 4);
        for (int k = nd - 1; k >= 0; k--)
            push_byte(atcw_pkg::CH_ZERO + 8'(dig[k]));
    endtask

    // one burst of console traffic, mostly well-formed text and color sequences
    task automatic send_chunk();
        int         kind;
        int         len;
        int         sel;
        logic [7:0] b;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2:
            begin
                len = $urandom_range(1, 8);
                repeat (len)
                begin
                    b = 8'($urandom_range(0, 255));
                    if (b == atcw_pkg::CH_ESC)
                        b = atcw_pkg::CH_SP;
                    push_byte(b);
                end
            end
            3, 4:
            begin
                len = $urandom_range(1, 6);
                repeat (len) push_byte(atcw_pkg::CH_NL);
            end
            5, 6:
            begin
                push_byte(atcw_pkg::CH_ESC);
                push_byte(atcw_pkg::CH_LBR);
                sel = $urandom_range(0, 5);
                case (sel)
                    0: send_code(0, 0);
                    1: send_code(30 + $urandom_range(0, 7), 0);
                    2: send_code(40 + $urandom_range(0, 7), 0);
                    3: send_code($urandom_range(0, 999), 0);
                    4: ;    // no digits, acts as a reset
                    default: send_code($urandom_range(0, 47), $urandom_range(1, 3));
                endcase
                push_byte(atcw_pkg::CH_M);
            end
            7:
            begin
                // broken sequences: lone esc, or a foreign terminator
                push_byte(atcw_pkg::CH_ESC);
                if ($urandom_range(0, 1) == 0)
                    push_byte(8'($urandom_range(0, 255)));
                else
                begin
                    push_byte(atcw_pkg::CH_LBR);
                    send_code($urandom_range(0, 99), 0);
                    push_byte(8'($urandom_range(0, 255)));
                end
            end
            8:
                push_byte(8'($urandom_range(0, 255)));
            default:
            begin
                // long line, likely to wrap at the right edge
                len = $urandom_range(75, 85);
                repeat (len) push_byte(8'($urandom_range(32, 126)));
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fails++;
        end
    endtask

    // receiver ready changes at the falling edge only
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_axis_tready = ($urandom_range(0, 99) >= dst_stall_pct);
        end
    end

    // result checker: every accepted transaction against the oldest expected command
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (cell_cmd_q.size() == 0)
            begin
                $error("unexpected result transaction: tdata %h tlast %b",
                       m_axis_tdata, m_axis_tlast);
                fails++;
            end
            else
            begin
                mon_want = cell_cmd_q.pop_front();
                mon_got  = atcw_pkg::res_t'(m_axis_tdata[RES_W-1:0]);
                check_field("cell_write", 32'(mon_want.res.cell_write),
                            32'(mon_got.cell_write));
                check_field("cell_index", 32'(mon_want.res.cell_index),
                            32'(mon_got.cell_index));
                check_field("cell_entry", 32'(mon_want.res.cell_entry),
                            32'(mon_got.cell_entry));
                check_field("scroll_up", 32'(mon_want.res.scroll_up),
                            32'(mon_got.scroll_up));
                check_field("blank_entry", 32'(mon_want.res.blank_entry),
                            32'(mon_got.blank_entry));
                check_field("cursor_write", 32'(mon_want.res.cursor_write),
                            32'(mon_got.cursor_write));
                check_field("cursor_pos", 32'(mon_want.res.cursor_pos),
                            32'(mon_got.cursor_pos));
                check_field("tdata pad", 32'd0,
                            32'(m_axis_tdata[atcw_pkg::TDATA_W-1:RES_W]));
                check_field("last", 32'(mon_want.last), 32'(m_axis_tlast));
            end
        end
    end

    // watchdog: cycles with no transaction on either side
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int target;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        rst_n         = 1'b0;

        // directed rows: extremes of the byte, newline, color set, dropped terminator,
        // saturated code, lone esc before a letter, esc esc, empty code
        dir_tab = '{
            '{8'h41,   1'b1, WANT_A},
            '{8'h00,   1'b1, WANT_NUL},
            '{8'hFF,   1'b1, WANT_FF},
            '{atcw_pkg::CH_NL,   1'b1, WANT_NL},
            '{atcw_pkg::CH_ESC,  1'b0, '0}, '{atcw_pkg::CH_LBR, 1'b0, '0},
            '{8'h33, 1'b0, '0},
            '{8'h31,   1'b0, '0}, '{atcw_pkg::CH_M,   1'b0, '0},
            '{atcw_pkg::CH_ESC,  1'b0, '0}, '{atcw_pkg::CH_LBR, 1'b0, '0},
            '{8'h34, 1'b0, '0},
            '{8'h37,   1'b0, '0}, '{8'h71,  1'b0, '0},
            '{atcw_pkg::CH_ESC,  1'b0, '0}, '{atcw_pkg::CH_LBR, 1'b0, '0},
            '{atcw_pkg::CH_NINE, 1'b0, '0},
            '{atcw_pkg::CH_NINE, 1'b0, '0}, '{atcw_pkg::CH_NINE, 1'b0, '0},
            '{atcw_pkg::CH_M, 1'b0, '0},
            '{atcw_pkg::CH_ESC,  1'b0, '0}, '{8'h7A,  1'b0, '0},
            '{atcw_pkg::CH_ESC,  1'b0, '0}, '{atcw_pkg::CH_ESC, 1'b0, '0},
            '{atcw_pkg::CH_LBR, 1'b0, '0},
            '{atcw_pkg::CH_M,    1'b0, '0},
            '{8'h78,   1'b0, '0}
        };

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_tab[i])
            push_byte(dir_tab[i].ch, dir_tab[i].lit, dir_tab[i].want);

        // random traffic in four flow-control phases
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:       begin src_idle_pct = 0;  dst_stall_pct = 0;  end
                1:       begin src_idle_pct = 78; dst_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  dst_stall_pct = 78; end
                default: begin src_idle_pct = 21; dst_stall_pct = 21; end
            endcase
            target = bytes_sent + RAND_ITEMS / 4;
            while (bytes_sent < target)
                send_chunk();
        end
        s_axis_tvalid = 1'b0;

        wait (cell_cmd_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fails == 0 && cell_cmd_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> ansi_text_console_writer_core.f
hw/rtl/atcw_pkg.sv
hw/rtl/atcw_decoder.sv
hw/rtl/atcw_result_fifo.sv
hw/rtl/ansi_text_console_writer_core.sv
dv/ansi_text_console_writer_core_tb.sv
